@@ src/fmt_pkg.sv @@
// fmt_pkg: types, register indexes, character codes and reciprocal constants
// shared by the fan mode / timer controller; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package fmt_pkg;

  // field widths fixed by the item format
  localparam int STEP_W  = 10;
  localparam int RUN_W   = 20;
  localparam int DUTY_W  = 10;
  localparam int TEMP_W  = 11;
  localparam int LAMP_W  = 3;
  localparam int CHAR_W  = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // quotient widths for the digit split
  localparam int QK_W   = 11;  // remaining / 1000, at most 1048
  localparam int QT_W   = 7;   // quotient / 10, at most 104
  localparam int QH_W   = 4;   // quotient / 100, at most 10
  localparam int T10_W  = 8;   // temperature / 10, at most 204
  localparam int T100_W = 5;   // temperature / 100, at most 20
  localparam int DIG_W  = 4;

  // reciprocals: floor(x * RECIP >> SHIFT) is exact over the ranges used here
  localparam logic [20:0] RECIP_1000  = 21'd1073742;
  localparam int          SHIFT_1000  = 30;
  localparam logic [12:0] RECIP_10    = 13'd6554;
  localparam int          SHIFT_10    = 16;
  localparam logic [10:0] RECIP_100   = 11'd1311;
  localparam int          SHIFT_100   = 17;

  // register reset values
  localparam logic [STEP_W-1:0] TICK_STEP_RST = 10'd20;
  localparam logic [RUN_W-1:0]  SHORT_RUN_RST = 20'd60000;
  localparam logic [RUN_W-1:0]  LONG_RUN_RST  = 20'd120000;
  localparam logic [DUTY_W-1:0] DUTY_SLP_RST  = 10'd200;
  localparam logic [DUTY_W-1:0] DUTY_NAT_RST  = 10'd300;
  localparam logic [DUTY_W-1:0] DUTY_CON_RST  = 10'd700;

  // ascii codes on the display
  localparam logic [CHAR_W-1:0] CH_DASH = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CH_FOUR = 7'h34;
  localparam logic [CHAR_W-1:0] CH_R    = 7'h72;
  localparam logic [CHAR_W-1:0] CH_C    = 7'h63;

  // lamp codes
  localparam logic [LAMP_W-1:0] LAMP_OFF = 3'b000;
  localparam logic [LAMP_W-1:0] LAMP_SLP = 3'b001;
  localparam logic [LAMP_W-1:0] LAMP_NAT = 3'b010;
  localparam logic [LAMP_W-1:0] LAMP_CON = 3'b100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_STEP = 3'd0,
    REG_SHORT_RUN = 3'd1,
    REG_LONG_RUN  = 3'd2,
    REG_DUTY_SLP  = 3'd3,
    REG_DUTY_NAT  = 3'd4,
    REG_DUTY_CON  = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    FAN_OFF      = 2'd0,
    FAN_SLEEP    = 2'd1,
    FAN_NATURAL  = 2'd2,
    FAN_CONSTANT = 2'd3
  } fan_mode_t;

  typedef enum logic [1:0] {
    TMR_NONE  = 2'd0,
    TMR_SHORT = 2'd1,
    TMR_LONG  = 2'd2
  } timer_mode_t;

  typedef enum logic [1:0] {
    KEY_FAN   = 2'd0,
    KEY_TIMER = 2'd1,
    KEY_HALT  = 2'd2,
    KEY_PAGE  = 2'd3
  } key_code_t;

  typedef struct packed {
    logic [STEP_W-1:0] tick_step_ms;
    logic [RUN_W-1:0]  short_run_ms;
    logic [RUN_W-1:0]  long_run_ms;
    logic [DUTY_W-1:0] duty_sleep;
    logic [DUTY_W-1:0] duty_natural;
    logic [DUTY_W-1:0] duty_constant;
  } cfg_t;

  // updated state handed from the state stage to the display pipeline
  typedef struct packed {
    fan_mode_t         fan_mode;
    logic              page_is_temp;
    logic [RUN_W-1:0]  remaining_ms;
    logic [TEMP_W-1:0] temp_tenths;
  } disp_t;

endpackage

`default_nettype wire

@@ src/fmt_in_if.sv @@
// fmt_in_if: valid/ready channel carrying one control tick item
// depends on fmt_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface fmt_in_if import fmt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              key_valid;
  logic [1:0]        key_code;
  logic [TEMP_W-1:0] temp_tenths;

  modport source (output valid, key_valid, key_code, temp_tenths, input ready);
  modport sink   (input valid, key_valid, key_code, temp_tenths, output ready);
endinterface

`default_nettype wire

@@ src/fmt_out_if.sv @@
// fmt_out_if: valid/ready channel carrying one result item (duty, lamps, display)
// depends on fmt_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface fmt_out_if import fmt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] pwm_duty;
  logic [LAMP_W-1:0] lamp_code;
  logic [CHAR_W-1:0] char_a;
  logic [CHAR_W-1:0] char_b;
  logic [CHAR_W-1:0] char_c;
  logic [CHAR_W-1:0] char_d;
  logic [CHAR_W-1:0] char_e;
  logic [CHAR_W-1:0] char_f;
  logic [CHAR_W-1:0] char_g;
  logic [CHAR_W-1:0] char_h;

  modport source (output valid, pwm_duty, lamp_code, char_a, char_b, char_c, char_d,
                  char_e, char_f, char_g, char_h, input ready);
  modport sink   (input valid, pwm_duty, lamp_code, char_a, char_b, char_c, char_d,
                  char_e, char_f, char_g, char_h, output ready);
endinterface

`default_nettype wire

@@ src/fan_mode_timer_controller.sv @@
// Fan mode and run timer controller: one control tick item in, one result item
// out. A tick with a key event steps the fan mode (sleep, natural, constant),
// the timer (none, short, long), stops, or flips the display page; the run time
// counts down by tick_step_ms each tick and an expired timer turns the fan off.
// One item is taken every clock cycle while the output is not stalled; the
// result passes the input register, state update, two digit stages and output
// register. The rate is set by the state update, which reads and writes the
// mode and run time registers once per item. Configuration writes (index 0
// tick step, 1 short run, 2 long run, 3..5 duty for sleep, natural, constant)
// take effect at once and are meant for an idle block.
// Depends on fmt_pkg, fmt_in_if, fmt_out_if, fmt_cfg_regs, fmt_state, fmt_display.
`timescale 1ns / 1ps
`default_nettype none

module fan_mode_timer_controller import fmt_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  fmt_in_if.sink                     in_ch,
  fmt_out_if.source                  out_ch
);

  cfg_t  cfg;
  logic  s1_valid;
  disp_t s1_item;
  logic  s1_ready;

  // configuration registers
  fmt_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // tick state update
  fmt_state u_state (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_ch    (in_ch),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_ready (s1_ready)
  );

  // digits, duty, lamps and output register
  fmt_display u_disp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_ready (s1_ready),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

@@ src/fmt_cfg_regs.sv @@
// fmt_cfg_regs: the six configuration registers behind a plain write port
// depends on fmt_pkg
`timescale 1ns / 1ps
`default_nettype none

module fmt_cfg_regs import fmt_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_step_ms  <= TICK_STEP_RST;
      cfg.short_run_ms  <= SHORT_RUN_RST;
      cfg.long_run_ms   <= LONG_RUN_RST;
      cfg.duty_sleep    <= DUTY_SLP_RST;
      cfg.duty_natural  <= DUTY_NAT_RST;
      cfg.duty_constant <= DUTY_CON_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TICK_STEP: cfg.tick_step_ms  <= cfg_data[STEP_W-1:0];
        REG_SHORT_RUN: cfg.short_run_ms  <= cfg_data[RUN_W-1:0];
        REG_LONG_RUN:  cfg.long_run_ms   <= cfg_data[RUN_W-1:0];
        REG_DUTY_SLP:  cfg.duty_sleep    <= cfg_data[DUTY_W-1:0];
        REG_DUTY_NAT:  cfg.duty_natural  <= cfg_data[DUTY_W-1:0];
        REG_DUTY_CON:  cfg.duty_constant <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/fmt_state.sv @@
// fmt_state: input register, tick state update (expiry, countdown, key) and
// the stage register holding the updated state; depends on fmt_pkg, fmt_in_if
`timescale 1ns / 1ps
`default_nettype none

module fmt_state import fmt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  fmt_in_if.sink    in_ch,
  output logic      s1_valid,
  output disp_t     s1_item,
  input  wire logic s1_ready
);

  // input register
  logic              s0_valid;
  logic              s0_key_valid;
  key_code_t         s0_key_code;
  logic [TEMP_W-1:0] s0_temp;

  // controller state
  fan_mode_t         fan_mode;
  timer_mode_t       timer_mode;
  logic              page_is_temp;
  logic [RUN_W-1:0]  remaining_ms;

  fan_mode_t         fan_next;
  timer_mode_t       timer_next;
  logic              page_next;
  logic [RUN_W-1:0]  remaining_next;

  logic s1_en;
  logic adv;

  assign s1_en       = !s1_valid || s1_ready;
  assign adv         = s0_valid && s1_en;
  assign in_ch.ready = !s0_valid || s1_en;

  // capture accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s0_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s0_key_valid <= in_ch.key_valid;
      s0_key_code  <= key_code_t'(in_ch.key_code);
      s0_temp      <= in_ch.temp_tenths;
    end
  end

  // expiry, countdown, then key action
  always_comb begin
    fan_next       = fan_mode;
    timer_next     = timer_mode;
    page_next      = page_is_temp;
    remaining_next = remaining_ms;
    if (timer_next != TMR_NONE && remaining_next == '0) begin
      timer_next = TMR_NONE;
      fan_next   = FAN_OFF;
    end
    if (remaining_next > RUN_W'(cfg.tick_step_ms)) begin
      remaining_next = remaining_next - RUN_W'(cfg.tick_step_ms);
    end else begin
      remaining_next = '0;
    end
    if (s0_key_valid) begin
      case (s0_key_code)
        KEY_FAN: begin
          if (timer_next != TMR_NONE) begin
            case (fan_next)
              FAN_OFF:     fan_next = FAN_SLEEP;
              FAN_SLEEP:   fan_next = FAN_NATURAL;
              FAN_NATURAL: fan_next = FAN_CONSTANT;
              default:     fan_next = FAN_SLEEP;
            endcase
          end
        end
        KEY_TIMER: begin
          page_next = 1'b0;
          case (timer_next)
            TMR_NONE: begin
              timer_next     = TMR_SHORT;
              remaining_next = cfg.short_run_ms;
              if (fan_next == FAN_OFF) fan_next = FAN_SLEEP;
            end
            TMR_SHORT: begin
              timer_next     = TMR_LONG;
              remaining_next = cfg.long_run_ms;
              if (fan_next == FAN_OFF) fan_next = FAN_SLEEP;
            end
            default: begin
              timer_next     = TMR_NONE;
              fan_next       = FAN_OFF;
              remaining_next = '0;
            end
          endcase
        end
        KEY_HALT: begin
          fan_next   = FAN_OFF;
          timer_next = TMR_NONE;
        end
        default: begin
          page_next = !page_next;
        end
      endcase
    end
  end

  // state registers move once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      fan_mode     <= FAN_OFF;
      timer_mode   <= TMR_NONE;
      page_is_temp <= 1'b0;
      remaining_ms <= '0;
    end else if (adv) begin
      fan_mode     <= fan_next;
      timer_mode   <= timer_next;
      page_is_temp <= page_next;
      remaining_ms <= remaining_next;
    end
  end

  // stage register toward the display pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item.fan_mode     <= fan_next;
      s1_item.page_is_temp <= page_next;
      s1_item.remaining_ms <= remaining_next;
      s1_item.temp_tenths  <= s0_temp;
    end
  end

  // fan runs exactly while a timer runs
  a_fan_tracks_timer: assert property (@(posedge clk) disable iff (rst)
    (fan_mode == FAN_OFF) == (timer_mode == TMR_NONE))
    else $error("fan mode and timer mode disagree");

  // run time only grows when a timer key loads it
  a_load_only_on_key: assert property (@(posedge clk) disable iff (rst)
    remaining_ms > $past(remaining_ms) |->
      $past(adv && s0_key_valid && s0_key_code == KEY_TIMER))
    else $error("remaining time grew without a timer key");

  // page flag changes only on an applied key
  a_page_on_key: assert property (@(posedge clk) disable iff (rst)
    page_is_temp != $past(page_is_temp) |-> $past(adv && s0_key_valid))
    else $error("display page changed without a key");

endmodule

`default_nettype wire

@@ src/fmt_display.sv @@
// fmt_display: digit split by reciprocal multiplies over two stages, then the
// output register with duty, lamps and characters; depends on fmt_pkg, fmt_out_if
`timescale 1ns / 1ps
`default_nettype none

module fmt_display import fmt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  s1_valid,
  input  wire disp_t s1_item,
  output logic       s1_ready,
  fmt_out_if.source  out_ch
);

  // stage 2: first quotients
  logic              s2_valid;
  fan_mode_t         s2_fan;
  logic              s2_page;
  logic [QK_W-1:0]   s2_qk;
  logic [T10_W-1:0]  s2_t10;
  logic [T100_W-1:0] s2_t100;

  // stage 3: second quotients and temperature digits
  logic              s3_valid;
  fan_mode_t         s3_fan;
  logic              s3_page;
  logic [QK_W-1:0]   s3_qk;
  logic [QT_W-1:0]   s3_qt;
  logic [QH_W-1:0]   s3_qh;
  logic [DIG_W-1:0]  s3_temp_hund;
  logic [DIG_W-1:0]  s3_temp_tens;

  logic out_en;
  logic s3_en;
  logic s2_en;

  logic [RUN_W+21-1:0]  prod_qk;
  logic [TEMP_W+13-1:0] prod_t10;
  logic [TEMP_W+11-1:0] prod_t100;
  logic [QK_W+13-1:0]   prod_qt;
  logic [QK_W+11-1:0]   prod_qh;
  logic [QT_W-1:0]      qt_next;
  logic [QH_W-1:0]      qh_next;
  logic [T100_W-1:0]    hund_sub;
  logic [T10_W-1:0]     tens_sub;
  logic [QK_W-1:0]      d1k_sub;
  logic [QT_W-1:0]      d10k_sub;
  logic [DIG_W-1:0]     d100k;

  logic [DUTY_W-1:0] duty_next;
  logic [LAMP_W-1:0] lamp_next;
  logic [CHAR_W-1:0] ch_next [8];

  // stall chain
  assign out_en   = !out_ch.valid || out_ch.ready;
  assign s3_en    = !s3_valid || out_en;
  assign s2_en    = !s2_valid || s3_en;
  assign s1_ready = s2_en;

  // divide by 1000, 10 and 100 through reciprocals
  assign prod_qk   = (RUN_W+21)'(s1_item.remaining_ms) * (RUN_W+21)'(RECIP_1000);
  assign prod_t10  = (TEMP_W+13)'(s1_item.temp_tenths) * (TEMP_W+13)'(RECIP_10);
  assign prod_t100 = (TEMP_W+11)'(s1_item.temp_tenths) * (TEMP_W+11)'(RECIP_100);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid) begin
      s2_fan  <= s1_item.fan_mode;
      s2_page <= s1_item.page_is_temp;
      s2_qk   <= prod_qk[SHIFT_1000 +: QK_W];
      s2_t10  <= prod_t10[SHIFT_10 +: T10_W];
      s2_t100 <= prod_t100[SHIFT_100 +: T100_W];
    end
  end

  // second quotients of the run time, temperature digits by remainder
  assign prod_qt  = (QK_W+13)'(s2_qk) * (QK_W+13)'(RECIP_10);
  assign prod_qh  = (QK_W+11)'(s2_qk) * (QK_W+11)'(RECIP_100);
  assign qt_next  = prod_qt[SHIFT_10 +: QT_W];
  assign qh_next  = prod_qh[SHIFT_100 +: QH_W];
  assign tens_sub = s2_t10 - T10_W'(s2_t100) * T10_W'(10);

  always_comb begin
    if (s2_t100 >= T100_W'(20)) begin
      hund_sub = s2_t100 - T100_W'(20);
    end else if (s2_t100 >= T100_W'(10)) begin
      hund_sub = s2_t100 - T100_W'(10);
    end else begin
      hund_sub = s2_t100;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en && s2_valid) begin
      s3_fan       <= s2_fan;
      s3_page      <= s2_page;
      s3_qk        <= s2_qk;
      s3_qt        <= qt_next;
      s3_qh        <= qh_next;
      s3_temp_hund <= hund_sub[DIG_W-1:0];
      s3_temp_tens <= tens_sub[DIG_W-1:0];
    end
  end

  // run time digits
  assign d1k_sub  = s3_qk - QK_W'(s3_qt) * QK_W'(10);
  assign d10k_sub = s3_qt - QT_W'(s3_qh) * QT_W'(10);
  assign d100k    = (s3_qh >= QH_W'(10)) ? s3_qh - QH_W'(10) : s3_qh;

  // duty and lamps from fan mode
  always_comb begin
    case (s3_fan)
      FAN_SLEEP: begin
        duty_next = cfg.duty_sleep;
        lamp_next = LAMP_SLP;
      end
      FAN_NATURAL: begin
        duty_next = cfg.duty_natural;
        lamp_next = LAMP_NAT;
      end
      FAN_CONSTANT: begin
        duty_next = cfg.duty_constant;
        lamp_next = LAMP_CON;
      end
      default: begin
        duty_next = '0;
        lamp_next = LAMP_OFF;
      end
    endcase
  end

  // display characters for the page
  always_comb begin
    if (s3_page) begin
      ch_next[0] = CH_DASH;
      ch_next[1] = CH_FOUR;
      ch_next[2] = CH_DASH;
      ch_next[3] = CH_R;
      ch_next[4] = CH_R;
      ch_next[5] = CH_ZERO + CHAR_W'(s3_temp_hund);
      ch_next[6] = CH_ZERO + CHAR_W'(s3_temp_tens);
      ch_next[7] = CH_C;
    end else if (s3_fan == FAN_OFF) begin
      for (int i = 0; i < 8; i++) ch_next[i] = CH_R;
    end else begin
      ch_next[0] = CH_DASH;
      ch_next[1] = CH_ZERO + CHAR_W'(s3_fan);
      ch_next[2] = CH_DASH;
      ch_next[3] = CH_R;
      ch_next[4] = CH_ZERO;
      ch_next[5] = CH_ZERO + CHAR_W'(d100k);
      ch_next[6] = CH_ZERO + CHAR_W'(d10k_sub[DIG_W-1:0]);
      ch_next[7] = CH_ZERO + CHAR_W'(d1k_sub[DIG_W-1:0]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_en) begin
      out_ch.valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s3_valid) begin
      out_ch.pwm_duty  <= duty_next;
      out_ch.lamp_code <= lamp_next;
      out_ch.char_a    <= ch_next[0];
      out_ch.char_b    <= ch_next[1];
      out_ch.char_c    <= ch_next[2];
      out_ch.char_d    <= ch_next[3];
      out_ch.char_e    <= ch_next[4];
      out_ch.char_f    <= ch_next[5];
      out_ch.char_g    <= ch_next[6];
      out_ch.char_h    <= ch_next[7];
    end
  end

  // at most one lamp lit on a shown item
  a_lamp_onehot: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> $onehot0(out_ch.lamp_code))
    else $error("more than one lamp lit");

  // an item only reaches the output from stage 3
  a_out_from_s3: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(s3_valid))
    else $error("result appeared without a stage 3 item");

  // run time digits are decimal digits
  a_run_digits: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.lamp_code != LAMP_OFF && out_ch.char_e == CH_ZERO |->
      out_ch.char_f >= CH_ZERO && out_ch.char_f <= CH_ZERO + 7'd9 &&
      out_ch.char_g >= CH_ZERO && out_ch.char_g <= CH_ZERO + 7'd9 &&
      out_ch.char_h >= CH_ZERO && out_ch.char_h <= CH_ZERO + 7'd9)
    else $error("run time digit out of range");

endmodule

`default_nettype wire

@@ test/fan_mode_timer_controller_tb.sv @@
// fan_mode_timer_controller_tb: drives control ticks into the fan/timer controller
// and checks every result item against a cycle-free model of the mode state
// depends on fmt_pkg, fmt_in_if, fmt_out_if and fan_mode_timer_controller
`timescale 1ns / 1ps

module fan_mode_timer_controller_tb;
  import fmt_pkg::*;

  // one result item as seen on the output channel
  typedef struct packed {
    logic [DUTY_W-1:0]           duty;
    logic [LAMP_W-1:0]           lamp;
    logic [0:7][CHAR_W-1:0]      chars;
  } panel_t;

  // mode state model plus the queue of panels still owed by the block
  class panel_scoreboard;
    cfg_t              cfg;
    fan_mode_t         fan;
    logic [1:0]        tmr;
    logic              page_temp;
    logic [RUN_W-1:0]  remain;
    panel_t            owed[$];
    int                errors;

    function new();
      cfg.tick_step_ms  = TICK_STEP_RST;
      cfg.short_run_ms  = SHORT_RUN_RST;
      cfg.long_run_ms   = LONG_RUN_RST;
      cfg.duty_sleep    = DUTY_SLP_RST;
      cfg.duty_natural  = DUTY_NAT_RST;
      cfg.duty_constant = DUTY_CON_RST;
      fan       = FAN_OFF;
      tmr       = TMR_NONE;
      page_temp = 1'b0;
      remain    = '0;
      errors    = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_TICK_STEP: cfg.tick_step_ms  = val[STEP_W-1:0];
        REG_SHORT_RUN: cfg.short_run_ms  = val[RUN_W-1:0];
        REG_LONG_RUN:  cfg.long_run_ms   = val[RUN_W-1:0];
        REG_DUTY_SLP:  cfg.duty_sleep    = val[DUTY_W-1:0];
        REG_DUTY_NAT:  cfg.duty_natural  = val[DUTY_W-1:0];
        REG_DUTY_CON:  cfg.duty_constant = val[DUTY_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [CHAR_W-1:0] ascii_digit(int unsigned v, int unsigned div);
      return CHAR_W'((v / div) % 10 + int'(CH_ZERO));
    endfunction

    // advance the mode state by one tick and queue the panel it shows
    function void note_tick(logic kv, logic [1:0] kc, logic [TEMP_W-1:0] temp);
      panel_t p;
      // expired timer stops the fan
      if (tmr != TMR_NONE && remain == 0) begin
        tmr = TMR_NONE;
        fan = FAN_OFF;
      end
      // saturating countdown
      if (remain > cfg.tick_step_ms) remain = remain - cfg.tick_step_ms;
      else remain = '0;
      // key action
      if (kv) begin
        case (key_code_t'(kc))
          KEY_FAN: begin
            if (tmr != TMR_NONE)
              fan = (fan == FAN_CONSTANT) ? FAN_SLEEP : fan_mode_t'(fan + 2'd1);
          end
          KEY_TIMER: begin
            page_temp = 1'b0;
            if (tmr == TMR_NONE) begin
              tmr = TMR_SHORT;
              remain = cfg.short_run_ms;
              if (fan == FAN_OFF) fan = FAN_SLEEP;
            end else if (tmr == TMR_SHORT) begin
              tmr = TMR_LONG;
              remain = cfg.long_run_ms;
              if (fan == FAN_OFF) fan = FAN_SLEEP;
            end else begin
              tmr = TMR_NONE;
              fan = FAN_OFF;
              remain = '0;
            end
          end
          KEY_HALT: begin
            fan = FAN_OFF;
            tmr = TMR_NONE;
          end
          default: page_temp = ~page_temp;
        endcase
      end
      // duty and lamps
      case (fan)
        FAN_SLEEP:    begin p.duty = cfg.duty_sleep;    p.lamp = LAMP_SLP; end
        FAN_NATURAL:  begin p.duty = cfg.duty_natural;  p.lamp = LAMP_NAT; end
        FAN_CONSTANT: begin p.duty = cfg.duty_constant; p.lamp = LAMP_CON; end
        default:      begin p.duty = '0;                p.lamp = LAMP_OFF; end
      endcase
      // display characters
      if (page_temp) begin
        p.chars[0] = CH_DASH;
        p.chars[1] = CH_FOUR;
        p.chars[2] = CH_DASH;
        p.chars[3] = CH_R;
        p.chars[4] = CH_R;
        p.chars[5] = ascii_digit(32'(temp), 100);
        p.chars[6] = ascii_digit(32'(temp), 10);
        p.chars[7] = CH_C;
      end else if (fan == FAN_OFF) begin
        for (int i = 0; i < 8; i++) p.chars[i] = CH_R;
      end else begin
        p.chars[0] = CH_DASH;
        p.chars[1] = CH_ZERO + CHAR_W'(fan);
        p.chars[2] = CH_DASH;
        p.chars[3] = CH_R;
        p.chars[4] = CH_ZERO;
        p.chars[5] = ascii_digit(32'(remain), 100000);
        p.chars[6] = ascii_digit(32'(remain), 10000);
        p.chars[7] = ascii_digit(32'(remain), 1000);
      end
      owed.push_back(p);
    endfunction

    function void cmp(string name, logic [RUN_W-1:0] exp, logic [RUN_W-1:0] act);
      if (act !== exp) begin
        $error("%s: expected %0d, got %0d", name, exp, act);
        errors++;
      end
    endfunction

    function void check_panel(panel_t got);
      panel_t exp;
      if (owed.size() == 0) begin
        $error("result item with no tick waiting for it");
        errors++;
        return;
      end
      exp = owed.pop_front();
      cmp("pwm_duty", RUN_W'(exp.duty), RUN_W'(got.duty));
      cmp("lamp_code", RUN_W'(exp.lamp), RUN_W'(got.lamp));
      for (int i = 0; i < 8; i++)
        cmp($sformatf("char_%c", 8'd97 + i), RUN_W'(exp.chars[i]), RUN_W'(got.chars[i]));
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    src_idle;
  int                    snk_idle;
  panel_scoreboard       sb;

  fmt_in_if  in_ch ();
  fmt_out_if out_ch ();

  fan_mode_timer_controller dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #4000000;
    $display("fan_mode_timer_controller_tb NOT OK");
    $finish;
  end

  // receiver back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
    end
  end

  // monitor: check results first, then note ticks taken at the same edge
  initial begin
    sb = new();
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_ch.valid && out_ch.ready)
          sb.check_panel({out_ch.pwm_duty, out_ch.lamp_code, out_ch.char_a, out_ch.char_b,
                          out_ch.char_c, out_ch.char_d, out_ch.char_e, out_ch.char_f,
                          out_ch.char_g, out_ch.char_h});
        if (in_ch.valid && in_ch.ready)
          sb.note_tick(in_ch.key_valid, in_ch.key_code, in_ch.temp_tenths);
      end
    end
  end

  // send one tick item, with random idle cycles ahead of it
  task automatic send_tick(logic kv, logic [1:0] kc, logic [TEMP_W-1:0] temp);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.key_valid   <= kv;
    in_ch.key_code    <= kc;
    in_ch.temp_tenths <= temp;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // hold the sender off until every owed panel has come out
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  // write all six registers on an idle block
  task automatic configure(logic [CFG_DATA_W-1:0] step, logic [CFG_DATA_W-1:0] short_run,
                           logic [CFG_DATA_W-1:0] long_run, logic [CFG_DATA_W-1:0] d_slp,
                           logic [CFG_DATA_W-1:0] d_nat, logic [CFG_DATA_W-1:0] d_con);
    reg_idx_t               idx [6];
    logic [CFG_DATA_W-1:0]  val [6];
    idx = '{REG_TICK_STEP, REG_SHORT_RUN, REG_LONG_RUN, REG_DUTY_SLP, REG_DUTY_NAT,
            REG_DUTY_CON};
    val = '{step, short_run, long_run, d_slp, d_nat, d_con};
    drain();
    repeat (6) @(negedge clk);
    for (int i = 0; i < 6; i++) begin
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      sb.set_reg(idx[i], val[i]);
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // random tick: mostly timer and fan keys so the timer keeps running
  task automatic send_random_tick();
    logic [1:0] kc;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3)      kc = KEY_FAN;
    else if (r < 7) kc = KEY_TIMER;
    else if (r < 8) kc = KEY_HALT;
    else            kc = KEY_PAGE;
    if ($urandom_range(0, 99) < 60) kc = 2'($urandom_range(0, 3)) & kc | kc;
    send_tick($urandom_range(0, 99) < 40, kc, TEMP_W'($urandom_range(0, 2047)));
  endtask

  task automatic random_phase(int items, bit hold_once);
    for (int n = 0; n < items; n++) begin
      if (hold_once && n == items / 2) drain();
      send_random_tick();
    end
  endtask

  // stimulus
  initial begin
    rst               = 1'b1;
    cfg_wr_en         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.key_valid   = 1'b0;
    in_ch.key_code    = '0;
    in_ch.temp_tenths = '0;
    src_idle          = 29;
    snk_idle          = 63;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: key handling and display pages
    send_tick(1'b0, KEY_TIMER, 11'd1250);   // key code ignored without key_valid
    send_tick(1'b0, KEY_PAGE, 11'd0);
    send_tick(1'b1, KEY_FAN, 11'd5);        // fan key does nothing without a timer
    send_tick(1'b1, KEY_PAGE, 11'd1250);
    send_tick(1'b1, KEY_PAGE, 11'd999);
    send_tick(1'b1, KEY_TIMER, 11'd345);    // short timer, fan to sleep
    send_tick(1'b1, KEY_FAN, 11'd0);
    send_tick(1'b1, KEY_FAN, 11'd0);
    send_tick(1'b1, KEY_FAN, 11'd2047 & 11'd1023);  // constant wraps to sleep
    send_tick(1'b1, KEY_PAGE, 11'd1234);
    send_tick(1'b1, KEY_TIMER, 11'd77);     // long timer
    send_tick(1'b1, KEY_TIMER, 11'd77);     // back to no timer
    send_tick(1'b1, KEY_TIMER, 11'd1);
    send_tick(1'b1, KEY_HALT, 11'd1);       // remaining time keeps counting
    send_tick(1'b0, KEY_HALT, 11'd1);

    // big step, short run and zero long run: saturation and expiry
    configure(20'd1000, 20'd2500, 20'd0, 20'd1023, 20'd0, 20'd1000);
    send_tick(1'b1, KEY_TIMER, 11'd0);
    send_tick(1'b0, KEY_FAN, 11'd0);
    send_tick(1'b0, KEY_FAN, 11'd0);
    send_tick(1'b0, KEY_FAN, 11'd0);        // counts past zero
    send_tick(1'b0, KEY_FAN, 11'd0);        // timer expired
    send_tick(1'b1, KEY_TIMER, 11'd0);
    send_tick(1'b1, KEY_TIMER, 11'd0);      // long timer loaded with zero
    send_tick(1'b1, KEY_FAN, 11'd0);
    send_tick(1'b0, KEY_FAN, 11'd0);

    // zero step and the longest runs the display can show
    configure(20'd0, 20'd999999, 20'd999999, 20'd200, 20'd300, 20'd700);
    send_tick(1'b1, KEY_TIMER, 11'd500);
    send_tick(1'b0, KEY_TIMER, 11'd500);
    send_tick(1'b1, KEY_TIMER, 11'd500);
    send_tick(1'b1, KEY_FAN, 11'd500);

    // random: receiver idles more, short runs so timers expire often
    configure(20'd1000, CFG_DATA_W'($urandom_range(0, 30000)),
              CFG_DATA_W'($urandom_range(0, 60000)), CFG_DATA_W'($urandom_range(0, 1000)),
              CFG_DATA_W'($urandom_range(0, 1000)), CFG_DATA_W'($urandom_range(0, 1000)));
    random_phase(670, 1'b1);

    // random: sender idles more, longest displayable runs show every digit
    src_idle = 63;
    snk_idle = 29;
    configure(CFG_DATA_W'($urandom_range(1, 1000)), 20'd999999, 20'd999999,
              20'd1000, CFG_DATA_W'($urandom_range(0, 1000)), 20'd0);
    random_phase(670, 1'b0);

    // random: back to back, small steps and runs
    src_idle = 0;
    snk_idle = 0;
    configure(CFG_DATA_W'($urandom_range(1, 50)), CFG_DATA_W'($urandom_range(0, 2000)),
              CFG_DATA_W'($urandom_range(0, 5000)), CFG_DATA_W'($urandom_range(0, 1000)),
              CFG_DATA_W'($urandom_range(0, 1000)), CFG_DATA_W'($urandom_range(0, 1000)));
    random_phase(670, 1'b0);

    // wait for the last panels, then report the result
    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("fan_mode_timer_controller_tb OK");
    end else begin
      $display("fan_mode_timer_controller_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/fmt_pkg.sv
src/fmt_in_if.sv
src/fmt_out_if.sv
src/fmt_cfg_regs.sv
src/fmt_state.sv
src/fmt_display.sv
src/fan_mode_timer_controller.sv
test/fan_mode_timer_controller_tb.sv
